// ===== src/bvm_pkg.sv =====
`timescale 1ns / 1ps

package bvm_pkg;

  // averaging window
  localparam int WINDOW     = 10;
  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = 2 ** SAMPLE_W - 1;
  localparam int SUM_W      = $clog2(WINDOW * SAMPLE_MAX + 1);

  // sum / WINDOW as a multiply by a rounded-up reciprocal, exact over the sum range
  localparam int AVG_SH    = SUM_W + $clog2(WINDOW);
  localparam int AVG_RECIP = (2 ** AVG_SH + WINDOW - 1) / WINDOW;

  // centivolt scaling: cv = avg * CV_MUL / CV_DIV + CV_OFS
  localparam int CV_W   = 11;
  localparam int CV_MUL = 1886;
  localparam int CV_OFS = 50;
  localparam int DIV_SH = 10;
  localparam int CV_DIV = 2 ** DIV_SH - 1;
  localparam int PROD_W = $clog2(SAMPLE_MAX * CV_MUL + 1);

  // level = cv / 10, clamped
  localparam int LVL_SH    = 16;
  localparam int LVL_RECIP = (2 ** LVL_SH + 9) / 10;
  localparam int LEVEL_W   = 8;
  localparam int LEVEL_MAX = 255;

  localparam int TIMER_W    = 16;
  localparam int TH_W       = 11;
  localparam int ROUND_W    = 4;
  localparam int PS_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_INTERVAL    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_THRESHOLD = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ROUNDS     = CFG_IDX_W'(5);

  // register reset values
  localparam logic [TIMER_W-1:0] RST_SAMPLE_INTERVAL  = TIMER_W'(100);
  localparam logic [TIMER_W-1:0] RST_CHECK_INTERVAL   = TIMER_W'(1000);
  localparam logic [TIMER_W-1:0] RST_BEEP_INTERVAL    = TIMER_W'(200);
  localparam logic [TH_W-1:0]    RST_NORMAL_THRESHOLD = TH_W'(1110);
  localparam logic [TH_W-1:0]    RST_OFF_THRESHOLD    = TH_W'(222);
  localparam logic [ROUND_W-1:0] RST_CHECK_ROUNDS     = ROUND_W'(5);

  // power state codes
  localparam logic [PS_W-1:0] PS_OFF     = PS_W'(0);
  localparam logic [PS_W-1:0] PS_STARTUP = PS_W'(1);
  localparam logic [PS_W-1:0] PS_NORMAL  = PS_W'(2);
  localparam logic [PS_W-1:0] PS_CHECK   = PS_W'(3);
  localparam logic [PS_W-1:0] PS_WARNING = PS_W'(4);

  typedef struct packed {
    logic [TIMER_W-1:0] sample_interval;
    logic [TIMER_W-1:0] check_interval;
    logic [TIMER_W-1:0] beep_interval;
    logic [TH_W-1:0]    normal_threshold;
    logic [TH_W-1:0]    off_threshold;
    logic [ROUND_W-1:0] check_rounds;
  } cfg_t;

  // control that travels with each tick down the pipeline
  typedef struct packed {
    logic valid;
    logic smp;
    logic evl;
  } tok_t;

endpackage

// ===== src/battery_voltage_monitor.sv =====
`timescale 1ns / 1ps

// channel   valid        stall        payload
// -------   ----------   ----------   -------------------------------------------------
// input     in_valid_i   in_stall_o   adc_sample_i
// output    out_valid_o  out_stall_i  battery_level_o, power_state_o, beep_o, silence_o
//
// one tick per clock while nothing stalls; a result passes through
// six register stages from the window sum to the output register,
// the first of them loaded by its input transfer itself
// reset gives the register defaults, a zero window and startup mode; no clearing pass
// a stalled output holds; bubbles in the pipeline close up, so input keeps
// transferring until every stage is full

module battery_voltage_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bvm_pkg::SAMPLE_W-1:0]    adc_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bvm_pkg::LEVEL_W-1:0]     battery_level_o,
  output logic [bvm_pkg::PS_W-1:0]        power_state_o,
  output logic                            beep_o,
  output logic                            silence_o,
  input  logic                            cfg_we_i,
  input  logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bvm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  bvm_pkg::cfg_t cfg_q;
  bvm_pkg::tok_t front_tok, scale_tok;
  logic [bvm_pkg::SUM_W-1:0]   sum;
  logic [bvm_pkg::CV_W-1:0]    scale_cv;
  logic [bvm_pkg::LEVEL_W-1:0] scale_level;
  logic                        scale_ready, ctrl_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval  <= bvm_pkg::RST_SAMPLE_INTERVAL;
      cfg_q.check_interval   <= bvm_pkg::RST_CHECK_INTERVAL;
      cfg_q.beep_interval    <= bvm_pkg::RST_BEEP_INTERVAL;
      cfg_q.normal_threshold <= bvm_pkg::RST_NORMAL_THRESHOLD;
      cfg_q.off_threshold    <= bvm_pkg::RST_OFF_THRESHOLD;
      cfg_q.check_rounds     <= bvm_pkg::RST_CHECK_ROUNDS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bvm_pkg::CFG_SAMPLE_INTERVAL:  cfg_q.sample_interval  <= cfg_data_i;
        bvm_pkg::CFG_CHECK_INTERVAL:   cfg_q.check_interval   <= cfg_data_i;
        bvm_pkg::CFG_BEEP_INTERVAL:    cfg_q.beep_interval    <= cfg_data_i;
        bvm_pkg::CFG_NORMAL_THRESHOLD: cfg_q.normal_threshold <= cfg_data_i[bvm_pkg::TH_W-1:0];
        bvm_pkg::CFG_OFF_THRESHOLD:    cfg_q.off_threshold    <= cfg_data_i[bvm_pkg::TH_W-1:0];
        bvm_pkg::CFG_CHECK_ROUNDS:     cfg_q.check_rounds     <= cfg_data_i[bvm_pkg::ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  bvm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .cfg_i        (cfg_q),
    .next_ready_i (scale_ready),
    .tok_o        (front_tok),
    .sum_o        (sum)
  );

  bvm_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_i        (front_tok),
    .sum_i        (sum),
    .ready_o      (scale_ready),
    .next_ready_i (ctrl_ready),
    .tok_o        (scale_tok),
    .cv_o         (scale_cv),
    .level_o      (scale_level)
  );

  bvm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_i           (scale_tok),
    .cv_i            (scale_cv),
    .level_i         (scale_level),
    .cfg_i           (cfg_q),
    .ready_o         (ctrl_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .battery_level_o (battery_level_o),
    .power_state_o   (power_state_o),
    .beep_o          (beep_o),
    .silence_o       (silence_o)
  );

endmodule

// ===== src/bvm_cell.sv =====
`timescale 1ns / 1ps

module bvm_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [bvm_pkg::SAMPLE_W-1:0] d_i,
  output logic [bvm_pkg::SAMPLE_W-1:0] q_o
);

  logic [bvm_pkg::SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

// ===== src/bvm_front.sv =====
`timescale 1ns / 1ps

module bvm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bvm_pkg::SAMPLE_W-1:0] adc_sample_i,
  input  bvm_pkg::cfg_t                cfg_i,
  input  logic                         next_ready_i,
  output bvm_pkg::tok_t                tok_o,
  output logic [bvm_pkg::SUM_W-1:0]    sum_o
);

  logic [bvm_pkg::SAMPLE_W-1:0] cell_in  [bvm_pkg::WINDOW];
  logic [bvm_pkg::SAMPLE_W-1:0] cell_out [bvm_pkg::WINDOW];

  logic [bvm_pkg::TIMER_W-1:0] smp_timer_q, smp_timer_d;
  logic [bvm_pkg::TIMER_W-1:0] chk_timer_q, chk_timer_d;
  logic [bvm_pkg::SUM_W-1:0]   sum_q, sum_d;
  bvm_pkg::tok_t               tok_q;

  logic ready, accept, smp, evl, shift;

  assign ready      = !tok_q.valid || next_ready_i;
  assign accept     = in_valid_i && ready;
  assign in_stall_o = !ready;

  assign smp   = smp_timer_q >= cfg_i.sample_interval;
  assign evl   = chk_timer_q >= cfg_i.check_interval;
  assign shift = accept && smp;

  // window as a shift line: the last cell holds the oldest sample
  for (genvar g = 0; g < bvm_pkg::WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_in[g] = adc_sample_i;
    end else begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end
    bvm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (cell_in[g]),
      .q_o     (cell_out[g])
    );
  end

  always_comb begin
    sum_d       = sum_q;
    smp_timer_d = smp_timer_q;
    chk_timer_d = chk_timer_q;
    if (accept) begin
      smp_timer_d = smp ? '0 : smp_timer_q + 1'b1;
      chk_timer_d = evl ? '0 : chk_timer_q + 1'b1;
      if (smp) begin
        sum_d = sum_q - bvm_pkg::SUM_W'(cell_out[bvm_pkg::WINDOW-1])
                      + bvm_pkg::SUM_W'(adc_sample_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_timer_q <= '0;
      chk_timer_q <= '0;
      sum_q       <= '0;
      tok_q       <= '0;
    end else begin
      smp_timer_q <= smp_timer_d;
      chk_timer_q <= chk_timer_d;
      sum_q       <= sum_d;
      if (ready) begin
        tok_q <= '{valid: in_valid_i, smp: smp, evl: evl};
      end
    end
  end

  // the running sum after a transfer is exactly this stage's payload
  assign tok_o = tok_q;
  assign sum_o = sum_q;

endmodule

// ===== src/bvm_scale.sv =====
`timescale 1ns / 1ps

module bvm_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bvm_pkg::tok_t                tok_i,
  input  logic [bvm_pkg::SUM_W-1:0]    sum_i,
  output logic                         ready_o,
  input  logic                         next_ready_i,
  output bvm_pkg::tok_t                tok_o,
  output logic [bvm_pkg::CV_W-1:0]     cv_o,
  output logic [bvm_pkg::LEVEL_W-1:0]  level_o
);

  localparam int AVG_PW = bvm_pkg::SUM_W + bvm_pkg::AVG_SH;
  localparam int T_W    = bvm_pkg::PROD_W + bvm_pkg::DIV_SH + 1;
  localparam int R_W    = bvm_pkg::PROD_W + 1;
  localparam int LVL_PW = bvm_pkg::CV_W + bvm_pkg::LVL_SH;

  bvm_pkg::tok_t tok2_q, tok3_q, tok4_q, tok5_q;
  logic ready2, ready3, ready4, ready5;

  logic [bvm_pkg::SAMPLE_W-1:0] avg_q;
  logic [bvm_pkg::PROD_W-1:0]   prod_q;
  logic [bvm_pkg::CV_W-1:0]     cv4_q, cv5_q;
  logic [bvm_pkg::LEVEL_W-1:0]  level5_q;

  logic [AVG_PW-1:0]            avg_full;
  logic [bvm_pkg::SAMPLE_W-1:0] avg_d;
  logic [bvm_pkg::PROD_W-1:0]   prod_d;
  logic [T_W-1:0]               prod_x;
  logic [bvm_pkg::CV_W-1:0]     quot_est, quot;
  logic [R_W-1:0]               rem;
  logic [bvm_pkg::CV_W-1:0]     cv_d;
  logic [LVL_PW-1:0]            lvl_full;
  logic [bvm_pkg::CV_W-1:0]     lvl_raw;
  logic [bvm_pkg::LEVEL_W-1:0]  level_d;

  // a stage loads when it is empty or its item moves on
  assign ready5  = !tok5_q.valid || next_ready_i;
  assign ready4  = !tok4_q.valid || ready5;
  assign ready3  = !tok3_q.valid || ready4;
  assign ready2  = !tok2_q.valid || ready3;
  assign ready_o = ready2;

  // average
  assign avg_full = AVG_PW'(sum_i) * AVG_PW'(bvm_pkg::AVG_RECIP);
  assign avg_d    = avg_full[bvm_pkg::AVG_SH +: bvm_pkg::SAMPLE_W];

  // scale to centivolt numerator
  assign prod_d = bvm_pkg::PROD_W'(avg_q) * bvm_pkg::PROD_W'(bvm_pkg::CV_MUL);

  // divide by 2^n - 1: estimate via (2^n + 1) / 2^2n, low by at most one
  always_comb begin
    prod_x   = (T_W'(prod_q) << bvm_pkg::DIV_SH) + T_W'(prod_q);
    quot_est = prod_x[2*bvm_pkg::DIV_SH +: bvm_pkg::CV_W];
    rem      = R_W'(prod_q) - (R_W'(quot_est) << bvm_pkg::DIV_SH) + R_W'(quot_est);
    quot     = (rem >= R_W'(bvm_pkg::CV_DIV)) ? quot_est + 1'b1 : quot_est;
    cv_d     = quot + bvm_pkg::CV_W'(bvm_pkg::CV_OFS);
  end

  // level in tenths of a volt
  always_comb begin
    lvl_full = LVL_PW'(cv4_q) * LVL_PW'(bvm_pkg::LVL_RECIP);
    lvl_raw  = lvl_full[bvm_pkg::LVL_SH +: bvm_pkg::CV_W];
    level_d  = (lvl_raw > bvm_pkg::CV_W'(bvm_pkg::LEVEL_MAX)) ?
               bvm_pkg::LEVEL_W'(bvm_pkg::LEVEL_MAX) : lvl_raw[bvm_pkg::LEVEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
      tok3_q <= '0;
      tok4_q <= '0;
      tok5_q <= '0;
    end else begin
      if (ready2) tok2_q <= tok_i;
      if (ready3) tok3_q <= tok2_q;
      if (ready4) tok4_q <= tok3_q;
      if (ready5) tok5_q <= tok4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2) avg_q  <= avg_d;
    if (ready3) prod_q <= prod_d;
    if (ready4) cv4_q  <= cv_d;
    if (ready5) begin
      cv5_q    <= cv4_q;
      level5_q <= level_d;
    end
  end

  assign tok_o   = tok5_q;
  assign cv_o    = cv5_q;
  assign level_o = level5_q;

endmodule

// ===== src/bvm_ctrl.sv =====
`timescale 1ns / 1ps

module bvm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bvm_pkg::tok_t               tok_i,
  input  logic [bvm_pkg::CV_W-1:0]    cv_i,
  input  logic [bvm_pkg::LEVEL_W-1:0] level_i,
  input  bvm_pkg::cfg_t               cfg_i,
  output logic                        ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bvm_pkg::LEVEL_W-1:0] battery_level_o,
  output logic [bvm_pkg::PS_W-1:0]    power_state_o,
  output logic                        beep_o,
  output logic                        silence_o
);

  typedef enum logic [bvm_pkg::PS_W-1:0] {
    M_OFF     = bvm_pkg::PS_OFF,
    M_STARTUP = bvm_pkg::PS_STARTUP,
    M_NORMAL  = bvm_pkg::PS_NORMAL,
    M_CHECK   = bvm_pkg::PS_CHECK,
    M_WARNING = bvm_pkg::PS_WARNING
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [bvm_pkg::ROUND_W-1:0]  prog_q, prog_d;
  logic [bvm_pkg::TIMER_W-1:0]  beep_timer_q, beep_timer_d;
  logic [bvm_pkg::CV_W-1:0]     cv_q, cv_eff;
  logic [bvm_pkg::LEVEL_W-1:0]  level_q, level_eff;
  logic                         out_valid_q, beep_q, silence_q;
  logic                         ready, load, quiet, beep;

  assign ready   = !out_valid_q || !out_stall_i;
  assign load    = tok_i.valid && ready;
  assign ready_o = ready;

  always_comb begin
    cv_eff    = tok_i.smp ? cv_i : cv_q;
    level_eff = tok_i.smp ? level_i : level_q;
    mode_d    = mode_q;
    prog_d    = prog_q;
    quiet     = 1'b0;
    if (tok_i.evl) begin
      unique case (mode_q)
        M_OFF: begin
          if (cv_eff > cfg_i.off_threshold) mode_d = M_STARTUP;
          else quiet = 1'b1;
        end
        M_STARTUP: begin
          mode_d = (cv_eff > cfg_i.normal_threshold) ? M_NORMAL : M_CHECK;
        end
        M_NORMAL: begin
          if (cv_eff < cfg_i.normal_threshold) begin
            mode_d = M_CHECK;
            prog_d = '0;
          end
        end
        M_CHECK: begin
          if (prog_q < cfg_i.check_rounds) begin
            prog_d = prog_q + 1'b1;
          end else if (cv_eff < cfg_i.normal_threshold) begin
            mode_d = M_WARNING;
          end
          if (cv_eff >= cfg_i.normal_threshold) mode_d = M_NORMAL;
        end
        M_WARNING: begin
          if (cv_eff > cfg_i.normal_threshold) mode_d = M_NORMAL;
          if (cv_eff < cfg_i.off_threshold) mode_d = M_OFF;
        end
        default: ;
      endcase
    end

    // beep sees the mode after this tick's evaluation
    beep = (mode_d == M_WARNING) &&
           ({1'b0, beep_timer_q} + 1'b1 >= {1'b0, cfg_i.beep_interval});
    if (beep) beep_timer_d = '0;
    else if (beep_timer_q != '1) beep_timer_d = beep_timer_q + 1'b1;
    else beep_timer_d = beep_timer_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_STARTUP;
      prog_q       <= '0;
      beep_timer_q <= '0;
      cv_q         <= '0;
      level_q      <= '0;
      out_valid_q  <= 1'b0;
      beep_q       <= 1'b0;
      silence_q    <= 1'b0;
    end else begin
      if (ready) out_valid_q <= tok_i.valid;
      if (load) begin
        mode_q       <= mode_d;
        prog_q       <= prog_d;
        beep_timer_q <= beep_timer_d;
        cv_q         <= cv_eff;
        level_q      <= level_eff;
        beep_q       <= beep;
        silence_q    <= quiet;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign battery_level_o = level_q;
  assign power_state_o   = mode_q;
  assign beep_o          = beep_q;
  assign silence_o       = silence_q;

endmodule

// ===== src/bvm_checker.sv =====
`timescale 1ns / 1ps

module bvm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [bvm_pkg::LEVEL_W-1:0]     battery_level_o,
  input  logic [bvm_pkg::PS_W-1:0]        power_state_o,
  input  logic                            beep_o,
  input  logic                            silence_o
);

  // a beep only comes out of warning
  a_beep_in_warning : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beep_o |-> power_state_o == bvm_pkg::PS_WARNING)
    else $error("beep outside warning");

  // silence only comes out of an off-state evaluation
  a_silence_in_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && silence_o |-> power_state_o == bvm_pkg::PS_OFF)
    else $error("silence outside off");

  // with the output register empty the whole pipeline can move
  a_empty_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(battery_level_o) &&
    $stable(power_state_o) && $stable(beep_o) && $stable(silence_o))
    else $error("stalled result changed");

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .battery_level_o (battery_level_o),
  .power_state_o   (power_state_o),
  .beep_o          (beep_o),
  .silence_o       (silence_o)
);
